// File: design/rtrd_pkg.sv
// ----------------------------------------------------------------------------
// rtrd_pkg
// Shared types and constants for the transparent-run decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rtrd_pkg;

  localparam int PIX_W = 8;   // pixel value
  localparam int IDX_W = 16;  // pixel position in the image
  localparam int POS_W = 17;  // pixel count, holds the full 65536
  localparam int CNT_W = 7;   // pixels per command, up to 64
  localparam int CFG_AW = 2;  // APB byte address
  localparam int CFG_DW = 32; // APB data

  localparam logic [PIX_W-1:0]  LITERAL_MAX = 8'd128;
  localparam logic [POS_W-1:0]  LIMIT_CAP   = 17'h10000;
  localparam logic [CFG_AW-1:0] ADDR_OUTPUT_LIMIT = 2'd0;

  // One unit of work for the back end: count pixels of one value at
  // consecutive positions starting at index; the final one carries tlast.
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/rle_transparent_run_decoder.sv
// ----------------------------------------------------------------------------
// rle_transparent_run_decoder
// Run-length decoder for literal and transparent zero runs.
// ----------------------------------------------------------------------------
// Each input item is one byte of the compressed stream, tuser marking the
// first count byte of an image. The input takes one item per cycle while the
// command queue (QUEUE_DEPTH entries) has space. Count bytes and dropped
// bytes produce nothing; a literal byte produces one pixel; a run byte
// produces up to MAX_RUN_PER_BEAT zero pixels. The output side emits one
// pixel per cycle while out_tready holds, so a run byte holds the output
// until all its pixels are out, and the input stalls once the queue fills
// behind it. Pixels past output_limit (at most 65536 per image) are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_transparent_run_decoder #(
  parameter int MAX_RUN_PER_BEAT = 64,
  parameter int QUEUE_DEPTH      = 4
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  input  wire  [7:0]                    in_tdata,   // [7:0] data_byte
  input  wire                           in_tuser,   // [0] frame_start
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [23:0]                   out_tdata,  // [7:0] pixel_value, [23:8] pixel_index
  output logic                          out_tlast,  // last_of_run
  input  wire                           cfg_psel,
  input  wire                           cfg_penable,
  input  wire                           cfg_pwrite,
  input  wire  [rtrd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire  [rtrd_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [rtrd_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import rtrd_pkg::*;

  logic [POS_W-1:0] output_limit_r, output_limit_nxt;
  logic             cfg_wr;

  logic             q_full;
  logic             q_push;
  cmd_t             q_push_cmd;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == ADDR_OUTPUT_LIMIT);

  always_comb begin
    output_limit_nxt = cfg_wr ? cfg_pwdata[POS_W-1:0] : output_limit_r;
    cfg_prdata       = '0;
    if (cfg_paddr == ADDR_OUTPUT_LIMIT) begin
      cfg_prdata = {{(CFG_DW-POS_W){1'b0}}, output_limit_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_limit_r <= LIMIT_CAP;
    end else begin
      output_limit_r <= output_limit_nxt;
    end
  end

  rtrd_front #(
    .MAX_RUN_PER_BEAT(MAX_RUN_PER_BEAT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .output_limit (output_limit_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_push_cmd)
  );

  rtrd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  rtrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// File: design/rtrd_front.sv
// ----------------------------------------------------------------------------
// rtrd_front
// Accepts stream bytes, tracks literal and pixel counts, and issues one
// command per byte that produces pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module rtrd_front #(
  parameter int MAX_RUN_PER_BEAT = 64
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [rtrd_pkg::PIX_W-1:0]   in_tdata,   // [7:0] data_byte
  input  wire                          in_tuser,   // [0] frame_start
  input  wire  [rtrd_pkg::POS_W-1:0]   output_limit,
  input  wire                          q_full,
  output logic                         q_push,
  output rtrd_pkg::cmd_t               q_cmd
);
  import rtrd_pkg::*;

  localparam logic [CNT_W-1:0] MAX_EMIT = CNT_W'(MAX_RUN_PER_BEAT);

  logic [PIX_W-1:0] literals_left_r, literals_left_nxt;
  logic [POS_W-1:0] pixels_out_r, pixels_out_nxt;

  logic             accept;
  logic [POS_W-1:0] limit_eff;
  logic [POS_W-1:0] po;
  logic [PIX_W-1:0] ll;
  logic [POS_W-1:0] room;
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] run_clip;
  logic [CNT_W-1:0] emit;
  logic [POS_W-1:0] first;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    limit_eff = output_limit[POS_W-1] ? LIMIT_CAP : output_limit;
    po        = in_tuser ? '0 : pixels_out_r;
    ll        = in_tuser ? '0 : literals_left_r;
    room      = (po < limit_eff) ? (limit_eff - po) : '0;
    run       = CNT_W'(in_tdata - LITERAL_MAX);
    run_clip  = ({{(POS_W-CNT_W){1'b0}}, run} > room) ? room[CNT_W-1:0] : run;
    emit      = (run_clip > MAX_EMIT) ? MAX_EMIT : run_clip;
    // leading pixels of a long run are skipped but keep their positions
    first     = po + POS_W'(run_clip) - POS_W'(emit);

    literals_left_nxt = literals_left_r;
    pixels_out_nxt    = pixels_out_r;
    q_push            = 1'b0;
    q_cmd.value       = in_tdata;
    q_cmd.index       = po[IDX_W-1:0];
    q_cmd.count       = CNT_W'(1);

    if (accept) begin
      literals_left_nxt = ll;
      pixels_out_nxt    = po;
      if (ll != '0) begin
        literals_left_nxt = ll - PIX_W'(1);
        if (room != '0) begin
          q_push         = 1'b1;
          pixels_out_nxt = po + POS_W'(1);
        end
      end else if (in_tdata <= LITERAL_MAX) begin
        literals_left_nxt = in_tdata;
      end else if (run_clip != '0) begin
        q_push         = 1'b1;
        q_cmd.value    = '0;
        q_cmd.index    = first[IDX_W-1:0];
        q_cmd.count    = emit;
        pixels_out_nxt = po + POS_W'(run_clip);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      literals_left_r <= '0;
      pixels_out_r    <= '0;
    end else begin
      literals_left_r <= literals_left_nxt;
      pixels_out_r    <= pixels_out_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/rtrd_queue.sv
// ----------------------------------------------------------------------------
// rtrd_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rtrd_queue #(
  parameter int DEPTH = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  rtrd_pkg::cmd_t     push_cmd,
  output logic               full,
  input  wire                pop,
  output logic               head_valid,
  output rtrd_pkg::cmd_t     head_cmd
);
  import rtrd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("command pushed into a full queue");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

// File: design/rtrd_back.sv
// ----------------------------------------------------------------------------
// rtrd_back
// Expands commands into pixels, one per cycle unless out_tready stalls it,
// through a registered output.
`default_nettype none

module rtrd_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_valid,
  input  rtrd_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [23:0]                  out_tdata,  // [7:0] pixel_value, [23:8] pixel_index
  output logic                         out_tlast   // last_of_run
);
  import rtrd_pkg::*;

  logic             cur_valid_r, cur_valid_nxt;
  logic [PIX_W-1:0] cur_value_r, cur_value_nxt;
  logic [IDX_W-1:0] cur_index_r, cur_index_nxt;
  logic [CNT_W-1:0] cur_left_r, cur_left_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_value_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_last_r;

  logic             load_out;
  logic             finishing;

  assign load_out  = cur_valid_r && (!out_valid_r || out_tready);
  assign finishing = load_out && (cur_left_r == CNT_W'(1));
  assign q_pop     = q_valid && (!cur_valid_r || finishing);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_value_nxt = cur_value_r;
    cur_index_nxt = cur_index_r;
    cur_left_nxt  = cur_left_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cur_value_nxt = q_cmd.value;
      cur_index_nxt = q_cmd.index;
      cur_left_nxt  = q_cmd.count;
    end else if (load_out) begin
      // advance to the next position of the run
      cur_valid_nxt = !finishing;
      cur_index_nxt = cur_index_r + IDX_W'(1);
      cur_left_nxt  = cur_left_r - CNT_W'(1);
    end

    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_value_r <= cur_value_nxt;
    cur_index_r <= cur_index_nxt;
    cur_left_r  <= cur_left_nxt;
    if (load_out) begin
      out_value_r <= cur_value_r;
      out_index_r <= cur_index_r;
      out_last_r  <= (cur_left_r == CNT_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_index_r, out_value_r};
  assign out_tlast  = out_last_r;

  a_active_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_left_r != '0))
    else $error("active command with no pixels left");

  a_mid_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> cur_valid_r)
    else $error("run ended without a marked last pixel");

  a_next_index_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !finishing) |=> (cur_index_r == out_index_r + IDX_W'(1)))
    else $error("run positions not consecutive");

endmodule

`default_nettype wire
